// File: design/histogram_chi_square_distance_defines.svh
// Assertion macros used by the chi-square distance top-level design file.
`ifndef HISTOGRAM_CHI_SQUARE_DISTANCE_DEFINES_SVH
`define HISTOGRAM_CHI_SQUARE_DISTANCE_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define HCSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcsd check failed");

// Check a consequence in the cycle after its trigger.
`define HCSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcsd check failed");

`endif

// File: design/hcsd_pkg.sv
// Package with widths and shared types of the chi-square distance block.
package hcsd_pkg;

    localparam int BIN_W   = 16;            // width of one histogram bin
    localparam int SUM_W   = BIN_W + 1;     // width of a + b
    localparam int PROD_W  = 2 * BIN_W;     // width of (a - b)^2
    localparam int QUOT_W  = BIN_W;         // a term never exceeds |a - b|
    localparam int DIST_W  = 25;            // width of the reported distance
    localparam int IN_TDATA_W  = 32;        // two bins, packed
    localparam int OUT_TDATA_W = 32;        // distance padded to whole bytes
    localparam int CNT_W   = $clog2(QUOT_W);

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // One finished term handed from the divider to the accumulator
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [QUOT_W-1:0] quot;
    } t_term;

endpackage

// File: design/histogram_chi_square_distance.sv
// Chi-square histogram distance: streams bin pairs, emits the sum per histogram.
//
// Each input word carries one bin of two histograms (unsigned Q0.16); the block
// adds (a-b)^2/(a+b), truncated, to a running sum and reports the sum, clamped
// at 25 bits (Q9.16), on the word marked tlast, then starts over from zero. An
// item is worked in steps, and no next word is taken until its term is added:
// capture |a-b| and a+b, square the difference, run the radix-2 divider that
// produces one quotient bit per cycle for all 16 quotient bits, then add the
// term. A waiting result word does not stall input until the next tlast term
// must be written into the output register.
`include "histogram_chi_square_distance_defines.svh"

module histogram_chi_square_distance (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [hcsd_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // bin_a[15:0], bin_b[31:16]
    input  logic                                i_s_tlast,   // last_bin
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [hcsd_pkg::OUT_TDATA_W-1:0]    o_m_tdata    // distance[24:0], zeros above
);
    import hcsd_pkg::*;

    logic             r_busy;
    logic             w_accept;
    logic             w_take;
    logic [BIN_W-1:0] w_a;
    logic [BIN_W-1:0] w_b;
    logic [BIN_W-1:0] w_diff;
    logic [SUM_W-1:0] w_sum;
    t_term            w_term;

    // Accept one word at a time
    assign o_s_tready = !r_busy;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Split the word and form |a-b| and a+b
    assign w_a    = i_s_tdata[BIN_W-1:0];
    assign w_b    = i_s_tdata[2*BIN_W-1:BIN_W];
    assign w_diff = (w_a > w_b) ? (w_a - w_b) : (w_b - w_a);
    assign w_sum  = SUM_W'(w_a) + SUM_W'(w_b);

    // Hold busy until the term has been added
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_take) begin
            r_busy <= 1'b0;
        end
    end

    hcsd_term u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_diff  (w_diff),
        .i_sum   (w_sum),
        .i_last  (i_s_tlast),
        .i_ack   (w_take),
        .o_term  (w_term)
    );

    hcsd_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_term     (w_term),
        .o_take     (w_take),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // A finished term only exists for an item in flight
    `HCSD_ASSERT_NOW(a_term_busy, i_clk, i_rst_n, w_term.valid, r_busy)
    // No second word is taken right behind an accepted one
    `HCSD_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, w_accept, !o_s_tready)
    // A result word appears only after a last term was added
    `HCSD_ASSERT_NOW(a_out_src, i_clk, i_rst_n, $rose(o_m_tvalid), $past(w_take && w_term.last))

endmodule

// File: design/hcsd_term.sv
// Term unit: squares |a-b| once, then divides by a+b one quotient bit per cycle.
module hcsd_term (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [hcsd_pkg::BIN_W-1:0]      i_diff,
    input  logic [hcsd_pkg::SUM_W-1:0]      i_sum,
    input  logic                            i_last,
    input  logic                            i_ack,
    output hcsd_pkg::t_term                 o_term
);
    import hcsd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [BIN_W-1:0]    r_diff;
    logic [SUM_W-1:0]    r_div;       // divisor a + b
    logic                r_zero;      // a + b was zero
    logic                r_last;
    logic [SUM_W-1:0]    r_rem;       // partial remainder, always below divisor
    logic [BIN_W-1:0]    r_low;       // dividend bits still to shift in, MSB first
    logic [QUOT_W-1:0]   r_quot;      // quotient bits shifted in, LSB last
    logic [PROD_W-1:0]   w_prod;
    logic [SUM_W:0]      w_trial;
    logic [SUM_W:0]      w_diffr;
    logic                w_ge;

    // Square the difference; the upper half is already below the divisor
    assign w_prod = PROD_W'(r_diff) * PROD_W'(r_diff);

    // One restoring step: bring down the next dividend bit and try a subtract
    assign w_trial = {r_rem, r_low[BIN_W-1]};
    assign w_diffr = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    // Sequence setup, division steps and hand-off
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (r_cnt == '0) n_state = S_DONE;
            S_DONE: if (i_ack) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath shift registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_diff <= i_diff;
                    r_div  <= i_sum;
                    r_zero <= (i_sum == '0);
                    r_last <= i_last;
                end
            end
            S_MUL: begin
                r_rem  <= SUM_W'(w_prod[PROD_W-1:BIN_W]);
                r_low  <= w_prod[BIN_W-1:0];
                r_quot <= '0;
                r_cnt  <= CNT_W'(QUOT_W - 1);
            end
            S_DIV: begin
                r_rem  <= w_ge ? w_diffr[SUM_W-1:0] : w_trial[SUM_W-1:0];
                r_low  <= {r_low[BIN_W-2:0], 1'b0};
                r_quot <= {r_quot[QUOT_W-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Present the term; an empty pair contributes nothing
    assign o_term.valid = (r_state == S_DONE);
    assign o_term.last  = r_last;
    assign o_term.quot  = r_zero ? '0 : r_quot;

endmodule

// File: design/hcsd_accum.sv
// Accumulator: adds terms with saturation and registers the distance word.
module hcsd_accum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hcsd_pkg::t_term                     i_term,
    output logic                                o_take,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [hcsd_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import hcsd_pkg::*;

    logic [DIST_W-1:0] r_sum;
    logic [DIST_W-1:0] r_dist;
    logic              r_valid;
    logic [DIST_W:0]   w_add;
    logic [DIST_W-1:0] w_sat;

    // Add the term and clamp at the largest distance
    assign w_add = {1'b0, r_sum} + (DIST_W + 1)'(i_term.quot);
    assign w_sat = w_add[DIST_W] ? DIST_MAX : w_add[DIST_W-1:0];

    // Take a term unless it must load a distance word that is still waiting
    assign o_take = i_term.valid && (!i_term.last || !r_valid || i_m_tready);

    // Running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (o_take) begin
            r_sum <= i_term.last ? '0 : w_sat;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take && i_term.last) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_term.last) begin
            r_dist <= w_sat;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_dist);

endmodule
